// ===== design/hslc_pkg.sv =====
// ----------------------------------------------------------------------------
// hslc_pkg
// shared types and constants for the hsl colorize pixel block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hslc_pkg;

  // one 8-bit color channel
  typedef logic [7:0] chan_t;

  // configuration register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_HUE  = 2'd0,
    REG_SAT  = 2'd1,
    REG_LOFF = 2'd2
  } reg_idx_t;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // reset values of the registers
  localparam chan_t HUE_RST  = 8'd0;
  localparam chan_t SAT_RST  = 8'd0;
  localparam chan_t LOFF_RST = 8'd128;

  // largest channel code
  localparam logic [9:0] CHAN_MAX = 10'd255;

  // hue sextant codes
  typedef enum logic [2:0] {
    SEXT_RY = 3'd0,
    SEXT_YG = 3'd1,
    SEXT_GC = 3'd2,
    SEXT_CB = 3'd3,
    SEXT_BM = 3'd4,
    SEXT_MR = 3'd5
  } sext_t;

endpackage

`default_nettype wire

// ===== design/hsl_colorize_pixel.sv =====
// ----------------------------------------------------------------------------
// hsl_colorize_pixel
// recolors an rgb pixel to a programmed hue and saturation, keeping its
// hsl lightness shifted by a programmable offset
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------
//  pixel in  | in        | start, busy               | red_in, green_in, blue_in
//  pixel out | out       | done (one-cycle strobe)   | red_out, green_out, blue_out
//  config    | in/out    | psel, penable, pwrite,    | paddr, pwdata, prdata
//            |           | pready                    |
//
//  - six-stage pipeline: an accepted pixel moves through stages 1 to 5 and
//    leaves the stage 6 output register with done high
//  - one pixel per clock; busy is never raised, the stages have no feedback
//  - the receiver cannot stall, so no stage ever holds; valid bits travel
//    with the data through each stage
//  - rst is synchronous; it clears the valid bits and loads the register
//    reset values (hue 0, saturation 0, lightness offset 128)
//  - the deepest stages are the l*saturation and (v-m)*fract multiplies
//
`timescale 1ns / 1ps
`default_nettype none

module hsl_colorize_pixel #(
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  // pixel in
  input  wire                          start,
  output logic                         busy,
  input  wire  hslc_pkg::chan_t        red_in,
  input  wire  hslc_pkg::chan_t        green_in,
  input  wire  hslc_pkg::chan_t        blue_in,
  // pixel out
  output logic                         done,
  output hslc_pkg::chan_t              red_out,
  output hslc_pkg::chan_t              green_out,
  output hslc_pkg::chan_t              blue_out,
  // configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [hslc_pkg::ADDR_W-1:0]  paddr,
  input  wire  [hslc_pkg::DATA_W-1:0]  pwdata,
  output logic [hslc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  import hslc_pkg::*;

  // widths: l is 0..1 in F+1 bits, v/m and channel values carry one guard bit
  localparam int LW = FRAC_BITS + 1;
  localparam int VW = FRAC_BITS + 2;
  localparam int SW = FRAC_BITS + 3;
  localparam int PW = FRAC_BITS + 10;

  localparam logic [LW-1:0] ONE  = LW'(1) << FRAC_BITS;
  localparam logic [LW-1:0] HALF = LW'(1) << (FRAC_BITS - 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  chan_t hue;
  chan_t saturation;
  chan_t lightness_offset;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue              <= HUE_RST;
      saturation       <= SAT_RST;
      lightness_offset <= LOFF_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HUE:  hue              <= pwdata[7:0];
        REG_SAT:  saturation       <= pwdata[7:0];
        REG_LOFF: lightness_offset <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_HUE:  prdata[7:0] = hue;
      REG_SAT:  prdata[7:0] = saturation;
      REG_LOFF: prdata[7:0] = lightness_offset;
      default:  prdata = '0;
    endcase
  end

  // hue * 6 splits into the sextant and an 8-bit fraction of it
  logic [10:0] hue6;
  assign hue6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

  // every pixel is taken as soon as it arrives
  assign busy = 1'b0;

  logic in_fire;
  assign in_fire = start && !busy;

  // --------------------------------------------------------------------------
  // stage 1: lightness from max+min plus offset, clamped to 0..1
  // --------------------------------------------------------------------------
  chan_t              mx, mn;
  logic [8:0]         mxmn;
  logic signed [SW-1:0] ls;
  logic [7:0]         loff_s;
  logic [LW-1:0]      l_next;

  always_comb begin
    mx = red_in;
    mn = red_in;
    if (green_in > mx) mx = green_in;
    if (blue_in  > mx) mx = blue_in;
    if (green_in < mn) mn = green_in;
    if (blue_in  < mn) mn = blue_in;
    mxmn   = {1'b0, mx} + {1'b0, mn};
    // offset - 128 as an 8-bit two's complement value
    loff_s = {~lightness_offset[7], lightness_offset[6:0]};
    ls = $signed({3'b000, mxmn, {(FRAC_BITS - 9){1'b0}}})
       + $signed({{2{loff_s[7]}}, loff_s, {(FRAC_BITS - 7){1'b0}}});
    if (ls[SW-1]) begin
      l_next = '0;
    end else if (ls[SW-2:0] > (SW-1)'(ONE)) begin
      l_next = ONE;
    end else begin
      l_next = ls[LW-1:0];
    end
  end

  logic          vld1;
  logic [LW-1:0] l1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      l1 <= l_next;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: t = l*s, s being saturation/256
  // --------------------------------------------------------------------------
  logic [LW+7:0] ls_prod;
  assign ls_prod = (LW+8)'(l1) * (LW+8)'(saturation);

  logic          vld2;
  logic [LW-1:0] l2;
  logic [LW-1:0] t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (vld1) begin
      l2 <= l1;
      t2 <= ls_prod[LW+7:8];
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: v and m
  // --------------------------------------------------------------------------
  logic [VW-1:0] s_ext, v_next, m_next, l2x2;

  always_comb begin
    s_ext = {2'b00, saturation, {(FRAC_BITS - 8){1'b0}}};
    if (l2 <= HALF) begin
      v_next = VW'(l2) + VW'(t2);
    end else begin
      v_next = VW'(l2) + s_ext - VW'(t2);
    end
    l2x2 = {l2, 1'b0};
    m_next = (l2x2 > v_next) ? (l2x2 - v_next) : '0;
  end

  logic          vld3;
  logic [VW-1:0] v3, m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (vld2) begin
      v3 <= v_next;
      m3 <= m_next;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: vsf = (v-m)*fract
  // --------------------------------------------------------------------------
  logic [VW+7:0] vsf_prod;
  assign vsf_prod = (VW+8)'(v3 - m3) * (VW+8)'(hue6[7:0]);

  logic          vld4;
  logic [VW-1:0] v4, m4, vsf4;
  logic [2:0]    sext4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (vld3) begin
      v4    <= v3;
      m4    <= m3;
      vsf4  <= vsf_prod[VW+7:8];
      sext4 <= hue6[10:8];
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: sextant select
  // --------------------------------------------------------------------------
  logic [VW-1:0] mid1, mid2, xr_next, xg_next, xb_next;

  always_comb begin
    mid1 = m4 + vsf4;
    mid2 = v4 - vsf4;
    case (sext4)
      SEXT_RY: begin xr_next = v4;   xg_next = mid1; xb_next = m4;   end
      SEXT_YG: begin xr_next = mid2; xg_next = v4;   xb_next = m4;   end
      SEXT_GC: begin xr_next = m4;   xg_next = v4;   xb_next = mid1; end
      SEXT_CB: begin xr_next = m4;   xg_next = mid2; xb_next = v4;   end
      SEXT_BM: begin xr_next = mid1; xg_next = m4;   xb_next = v4;   end
      default: begin xr_next = v4;   xg_next = m4;   xb_next = mid2; end
    endcase
  end

  logic          vld5;
  logic [VW-1:0] xr, xg, xb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else begin
      vld5 <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (vld4) begin
      xr <= xr_next;
      xg <= xg_next;
      xb <= xb_next;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: scale by 255, truncate, saturate
  // --------------------------------------------------------------------------
  function automatic chan_t to_chan(input logic [VW-1:0] x);
    logic [PW-1:0] p;
    logic [9:0]    c;
    p = {x, 8'h00} - PW'(x);
    c = p[PW-1:FRAC_BITS];
    to_chan = (c > CHAN_MAX) ? chan_t'(CHAN_MAX) : c[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld5;
    end
  end

  always_ff @(posedge clk) begin
    if (vld5) begin
      red_out   <= to_chan(xr);
      green_out <= to_chan(xg);
      blue_out  <= to_chan(xb);
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> ##6 done)
    else $error("pixel did not leave the pipeline after six cycles");

  a_l_range: assert property (@(posedge clk) disable iff (rst)
    vld1 |-> l1 <= ONE)
    else $error("lightness outside 0..1");

  a_m_le_v: assert property (@(posedge clk) disable iff (rst)
    vld3 |-> m3 <= v3)
    else $error("m above v");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    vld5 && $past(v4 == m4) |-> xr == xg && xg == xb)
    else $error("grey pixel came out with unequal channels");

endmodule

`default_nettype wire

// ===== verif/hsl_colorize_pixel_test.sv =====
// ----------------------------------------------------------------------------
// hsl_colorize_pixel_test
// self-checking bench: pixels are streamed through the colorizer under
// several register settings and idle patterns, and every output pixel is
// compared against a fixed-point prediction of the hsl recolor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_colorize_pixel_test;
  import hslc_pkg::*;

  // fraction bits of the fixed-point datapath, same as the dut
  localparam int FRAC = 16;
  // register index past the end of the map, writes there must be dropped
  localparam logic [1:0] REG_NONE = 2'd3;
  // pipeline is six deep, give it some slack after the last transaction
  localparam int TAIL_CYCLES = 12;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_PIXELS = 145;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // holds a copy of the registers and the queue of predicted output pixels
  class colorize_scoreboard;
    chan_t hue_reg;
    chan_t sat_reg;
    chan_t loff_reg;
    rgb_t  expected_pixels[$];
    int    mismatch_count;

    function new();
      hue_reg = HUE_RST;
      sat_reg = SAT_RST;
      loff_reg = LOFF_RST;
      mismatch_count = 0;
    endfunction

    function void load_register(logic [1:0] idx, chan_t val);
      case (idx)
        REG_HUE: hue_reg = val;
        REG_SAT: sat_reg = val;
        REG_LOFF: loff_reg = val;
        default: ;
      endcase
    endfunction

    function chan_t to_channel(logic [63:0] x);
      logic [63:0] c;
      c = (x * 64'd255) >> FRAC;
      return (c > 64'd255) ? 8'd255 : c[7:0];
    endfunction

    function rgb_t predict_colorize(rgb_t px);
      chan_t       mx;
      chan_t       mn;
      longint      ls;
      logic [63:0] one, l, h, s, t, v, m, h6, fract, vsf, mid1, mid2, r, g, b;
      sext_t       sextant;
      rgb_t        res;
      one = 64'd1 << FRAC;
      mx = px.red;
      mn = px.red;
      if (px.green > mx) mx = px.green;
      if (px.blue > mx) mx = px.blue;
      if (px.green < mn) mn = px.green;
      if (px.blue < mn) mn = px.blue;
      // lightness of the source pixel plus the signed offset, clamped to 0..1
      ls = (longint'(mx) + longint'(mn)) <<< (FRAC - 9);
      ls = ls + (longint'(loff_reg) - 64'sd128) * (longint'(1) <<< (FRAC - 7));
      if (ls < 0) ls = 0;
      if (ls > longint'(one)) ls = longint'(one);
      l = ls;
      h = 64'(hue_reg) << (FRAC - 8);
      s = 64'(sat_reg) << (FRAC - 8);
      t = (l * s) >> FRAC;
      if (l <= (one >> 1)) v = l + t;
      else v = l + s - t;
      r = l;
      g = l;
      b = l;
      if (v != 64'd0) begin
        m = ((l << 1) > v) ? (l << 1) - v : 64'd0;
        h6 = h * 64'd6;
        sextant = sext_t'(h6[FRAC+2:FRAC]);
        fract = h6 & (one - 64'd1);
        vsf = ((v - m) * fract) >> FRAC;
        mid1 = m + vsf;
        mid2 = v - vsf;
        case (sextant)
          SEXT_RY: begin r = v; g = mid1; b = m; end
          SEXT_YG: begin r = mid2; g = v; b = m; end
          SEXT_GC: begin r = m; g = v; b = mid1; end
          SEXT_CB: begin r = m; g = mid2; b = v; end
          SEXT_BM: begin r = mid1; g = m; b = v; end
          default: begin r = v; g = m; b = mid2; end
        endcase
      end
      res.red = to_channel(r);
      res.green = to_channel(g);
      res.blue = to_channel(b);
      return res;
    endfunction

    function void note_pixel(rgb_t px);
      expected_pixels.push_back(predict_colorize(px));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
      mismatch_count++;
    endtask

    task check_pixel(rgb_t got);
      rgb_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel with nothing expected, red", got.red, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red) report_mismatch("red_out", got.red, want.red);
        if (got.green !== want.green) report_mismatch("green_out", got.green, want.green);
        if (got.blue !== want.blue) report_mismatch("blue_out", got.blue, want.blue);
      end
    endtask

    task check_leftover();
      if (expected_pixels.size() != 0)
        report_mismatch("pixels never produced, count", 0, expected_pixels.size());
    endtask
  endclass

  // every input has a known value from time zero
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  chan_t               red_in = '0;
  chan_t               green_in = '0;
  chan_t               blue_in = '0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic                busy;
  logic                done;
  chan_t               red_out;
  chan_t               green_out;
  chan_t               blue_out;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  colorize_scoreboard sb = new();

  hsl_colorize_pixel #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .done(done),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // output side: done is a one-cycle strobe, the transaction is taken at the
  // edge that ends that cycle, values read here are the pre-edge ones
  always @(posedge clk) begin
    if (done) sb.check_pixel({red_out, green_out, blue_out});
  end

  // all driving tasks are entered and left at a falling edge

  // one pixel transaction, with random idle cycles in front of it; start
  // stays high on return so back-to-back pixels keep it asserted
  task automatic send_pixel(rgb_t px, int idle_pct);
    bit accepted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      // junk on the payload while start is low
      red_in <= 8'($urandom_range(255));
      green_in <= 8'($urandom_range(255));
      blue_in <= 8'($urandom_range(255));
      @(posedge clk);
      @(negedge clk);
    end
    start <= 1'b1;
    red_in <= px.red;
    green_in <= px.green;
    blue_in <= px.blue;
    do begin
      @(posedge clk);
      accepted = !busy;
      if (accepted) sb.note_pixel(px);
      @(negedge clk);
    end while (!accepted);
  endtask

  // drop start and let every predicted pixel come out, then let the
  // pipeline settle so register writes never overlap a pixel in flight
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // setup and access phase; upper data bits are random and must be ignored
  task automatic write_register(logic [1:0] idx, chan_t val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom), val};
    @(posedge clk);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.load_register(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly uniform pixels, with grays, near-grays and pure 0/255 mixes
  // mixed in since those sit on the edges of the max/min and lightness math
  function automatic rgb_t rand_pixel();
    rgb_t  px;
    chan_t base;
    base = 8'($urandom_range(255));
    case ($urandom_range(9))
      0: px = {base, base, base};
      1: begin
        px.red = base ^ 8'($urandom_range(3));
        px.green = base ^ 8'($urandom_range(3));
        px.blue = base ^ 8'($urandom_range(3));
      end
      2: begin
        px.red = {8{1'($urandom_range(1))}};
        px.green = {8{1'($urandom_range(1))}};
        px.blue = {8{1'($urandom_range(1))}};
      end
      default: begin
        px.red = 8'($urandom_range(255));
        px.green = 8'($urandom_range(255));
        px.blue = 8'($urandom_range(255));
      end
    endcase
    return px;
  endfunction

  initial begin
    int    hue_list[7];
    int    idle_plan[3];
    int    idle_pct;
    chan_t hue_val;
    chan_t sat_val;
    chan_t loff_val;

    // one hue per sextant, plus both ends of the hue range
    hue_list = '{0, 50, 90, 130, 175, 220, 255};
    // no idling, sender idle 45 of 100, sender idle 26 of 100 (only the sender can idle)
    idle_plan = '{0, 45, 26};

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register reset values: saturation 0 turns everything gray
    send_pixel({8'd0, 8'd0, 8'd0}, 0);
    send_pixel({8'd255, 8'd255, 8'd255}, 0);
    send_pixel({8'd255, 8'd0, 8'd0}, 0);
    send_pixel({8'd0, 8'd255, 8'd0}, 0);
    send_pixel({8'd0, 8'd0, 8'd255}, 0);
    send_pixel({8'd128, 8'd128, 8'd128}, 0);

    // full saturation, walk through every sextant of the hue circle
    wait_idle();
    write_register(REG_SAT, 8'd255);
    write_register(REG_LOFF, 8'd128);
    foreach (hue_list[i]) begin
      wait_idle();
      write_register(REG_HUE, chan_t'(hue_list[i]));
      send_pixel({8'd200, 8'd100, 8'd50}, 0);
    end

    // a write past the register map changes nothing
    wait_idle();
    write_register(REG_NONE, 8'd77);
    send_pixel({8'd200, 8'd100, 8'd50}, 0);

    // lowest offset drives lightness to zero: clamp at 0 and the zero-v path
    wait_idle();
    write_register(REG_LOFF, 8'd0);
    send_pixel({8'd255, 8'd255, 8'd255}, 0);
    send_pixel({8'd0, 8'd0, 8'd0}, 0);

    // highest offset saturates lightness at one
    wait_idle();
    write_register(REG_LOFF, 8'd255);
    send_pixel({8'd255, 8'd255, 8'd255}, 0);
    send_pixel({8'd10, 8'd20, 8'd30}, 0);

    // random part: register extremes first, then random settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_pct = idle_plan[ph % 3];
      case (ph)
        0: begin hue_val = 8'd0; sat_val = 8'd0; loff_val = 8'd0; end
        1: begin hue_val = 8'd255; sat_val = 8'd255; loff_val = 8'd255; end
        2: begin hue_val = 8'd255; sat_val = 8'd255; loff_val = 8'd0; end
        3: begin hue_val = 8'd0; sat_val = 8'd255; loff_val = 8'd128; end
        default: begin
          hue_val = 8'($urandom_range(255));
          sat_val = 8'($urandom_range(255));
          // keep the offset near neutral half the time so lightness isn't
          // always pinned at a clamp
          loff_val = ($urandom_range(1) != 0) ? 8'($urandom_range(160, 96))
                                              : 8'($urandom_range(255));
        end
      endcase
      wait_idle();
      write_register(REG_HUE, hue_val);
      write_register(REG_SAT, sat_val);
      write_register(REG_LOFF, loff_val);
      if (ph % 2 == 1) write_register(REG_NONE, 8'($urandom_range(255)));
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        // now and then the sender holds off until the pipeline is empty
        if ($urandom_range(59) == 0) wait_idle();
        send_pixel(rand_pixel(), idle_pct);
      end
    end

    wait_idle();
    sb.check_leftover();
    if (sb.mismatch_count == 0) begin
      $display("hsl_colorize_pixel_test OK");
    end else begin
      $display("hsl_colorize_pixel_test NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the length of a correct run
  initial begin
    #5_000_000;
    $display("hsl_colorize_pixel_test NOT OK");
    $finish;
  end

endmodule
